@@ rtl/hdut_pkg.sv @@
package hdut_pkg;

  localparam int BYTE_W         = 8;
  localparam int HALF_CNT_W     = 8;
  localparam int BIT_IDX_W      = 4;
  localparam int COUNT_W        = 5;
  localparam int FIFO_DEPTH_DEF = 16;

  // transmit bit positions: start at 0, data 1..8, stops from 9, done at 10
  localparam logic [BIT_IDX_W-1:0] TX_STOP_IDX = 4'd9;
  localparam logic [BIT_IDX_W-1:0] TX_LAST_IDX = 4'd10;
  // receive: stop sample comes after 8 data bits
  localparam logic [BIT_IDX_W-1:0] RX_STOP_IDX = 4'd8;
  // first half-bit count at which the line is sampled
  localparam logic [HALF_CNT_W-1:0] RX_FIRST_SAMPLE = 8'd3;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SEND = 2'd1,
    REQ_READ = 2'd2,
    REQ_ARM  = 2'd3
  } req_type_e;

endpackage

@@ rtl/hdut_req_if.sv @@
interface hdut_req_if;
  import hdut_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              rx_level;
  logic [BYTE_W-1:0] tx_byte;

  modport source (output valid, req_type, rx_level, tx_byte, input ready);
  modport sink   (input valid, req_type, rx_level, tx_byte, output ready);

endinterface

@@ rtl/hdut_rsp_if.sv @@
interface hdut_rsp_if;
  import hdut_pkg::*;

  logic               valid;
  logic               ready;
  logic               tx_level;
  logic               rx_done;
  logic [BYTE_W-1:0]  rx_data;
  logic [BYTE_W-1:0]  read_data;
  logic               read_valid;
  logic               send_accepted;
  logic               tx_busy;
  logic               rx_busy;
  logic [COUNT_W-1:0] fifo_count;
  logic               overflow;

  modport source (
    output valid, tx_level, rx_done, rx_data, read_data, read_valid,
           send_accepted, tx_busy, rx_busy, fifo_count, overflow,
    input  ready
  );
  modport sink (
    input  valid, tx_level, rx_done, rx_data, read_data, read_valid,
           send_accepted, tx_busy, rx_busy, fifo_count, overflow,
    output ready
  );

endinterface

@@ rtl/half_duplex_uart_transceiver.sv @@
// result: registered; it is valid in the cycle after its request item is accepted
// throughput: one item per cycle while no result is stalled; the receive fifo
//   memory has one read port with a registered output
// reset (rst_ni low, asynchronous): line idle high, both directions idle,
//   fifo empty, auto_listen set; fifo contents stay undefined, no clearing pass
module half_duplex_uart_transceiver #(
  parameter int FIFO_DEPTH = hdut_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  hdut_req_if.sink      req_i,
  hdut_rsp_if.source    rsp_o
);
  import hdut_pkg::*;

  // fifo pointer and fill count widths follow from the depth
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(FIFO_DEPTH);

  // registered result, all fields but the fifo read data
  typedef struct packed {
    logic               tx_level;
    logic               rx_done;
    logic [BYTE_W-1:0]  rx_data;
    logic               read_valid;
    logic               send_accepted;
    logic               tx_busy;
    logic               rx_busy;
    logic [COUNT_W-1:0] fifo_count;
    logic               overflow;
  } rsp_t;

  // shared transmit / receive state
  logic                  auto_listen_q;
  logic [HALF_CNT_W-1:0] half_cnt_q, half_cnt_d;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [BIT_IDX_W-1:0]  bit_idx_q, bit_idx_d;
  logic                  tx_act_q, tx_act_d;
  logic                  rx_act_q, rx_act_d;
  logic                  line_q, line_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;

  // receive fifo memory
  logic [BYTE_W-1:0]     fifo_mem [FIFO_DEPTH];
  logic                  mem_we;
  logic [PTR_W-1:0]      wr_addr;
  logic [SUM_W-1:0]      wr_sum;
  logic [BYTE_W-1:0]     rd_data_q;

  // output stage
  logic                  rsp_valid_q;
  rsp_t                  rsp_q, rsp_d;

  logic                  accept;
  req_type_e             req;

  // the output register parts the two sides: new items flow while the
  // result is taken in the same cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign req         = req_type_e'(req_i.req_type);

  // write slot behind the oldest entry, wrapped once at most
  assign wr_sum  = SUM_W'(rd_ptr_q) + SUM_W'(count_q);
  assign wr_addr = (wr_sum >= DEPTH_SUM) ? PTR_W'(wr_sum - DEPTH_SUM) : PTR_W'(wr_sum);

  always_comb begin
    logic start_ok;
    logic [HALF_CNT_W-1:0] hc;
    logic [BIT_IDX_W-1:0]  bm1;

    half_cnt_d = half_cnt_q;
    shift_d    = shift_q;
    bit_idx_d  = bit_idx_q;
    tx_act_d   = tx_act_q;
    rx_act_d   = rx_act_q;
    line_d     = line_q;
    rd_ptr_d   = rd_ptr_q;
    count_d    = count_q;
    mem_we     = 1'b0;
    rsp_d      = '0;
    hc         = '0;
    bm1        = '0;

    // start bit seen on an idle block
    start_ok = !tx_act_q && !rx_act_q && !req_i.rx_level;

    unique case (req)
      REQ_TICK: begin
        if (auto_listen_q && start_ok) begin
          rx_act_d  = 1'b1;
          shift_d   = '0;
          half_cnt_d = '0;
          bit_idx_d = '0;
        end
        hc         = half_cnt_d + 1'b1;
        half_cnt_d = hc;
        // line is handled on odd half-bit counts only
        if (hc[0]) begin
          if (tx_act_d) begin
            bm1 = bit_idx_d - 1'b1;
            if (bit_idx_d == '0) begin
              line_d = 1'b0;
            end else if (bit_idx_d < TX_STOP_IDX) begin
              line_d = shift_d[bm1[2:0]];
            end else begin
              line_d = 1'b1;
            end
            if (bit_idx_d == TX_LAST_IDX) begin
              tx_act_d = 1'b0;
            end
            bit_idx_d = bit_idx_d + 1'b1;
          end else if (rx_act_d && (hc >= RX_FIRST_SAMPLE)) begin
            if (bit_idx_d == RX_STOP_IDX) begin
              rx_act_d = 1'b0;
              if (req_i.rx_level) begin
                rsp_d.rx_done = 1'b1;
                rsp_d.rx_data = shift_d;
                if (count_q < DEPTH_C) begin
                  mem_we  = 1'b1;
                  count_d = count_q + 1'b1;
                end else begin
                  rsp_d.overflow = 1'b1;
                end
              end
            end else begin
              if (req_i.rx_level) begin
                shift_d[bit_idx_d[2:0]] = 1'b1;
              end
              bit_idx_d = bit_idx_d + 1'b1;
            end
          end
        end
      end
      REQ_SEND: begin
        // a send always aborts reception
        rx_act_d = 1'b0;
        if (!tx_act_q) begin
          bit_idx_d  = '0;
          shift_d    = req_i.tx_byte;
          half_cnt_d = '0;
          tx_act_d   = 1'b1;
          rsp_d.send_accepted = 1'b1;
        end
      end
      REQ_READ: begin
        if (count_q != '0) begin
          rsp_d.read_valid = 1'b1;
          rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      REQ_ARM: begin
        if (start_ok) begin
          rx_act_d   = 1'b1;
          shift_d    = '0;
          half_cnt_d = '0;
          bit_idx_d  = '0;
        end
      end
      default: ;
    endcase

    rsp_d.tx_level   = line_d;
    rsp_d.tx_busy    = tx_act_d;
    rsp_d.rx_busy    = rx_act_d;
    rsp_d.fifo_count = COUNT_W'(count_d);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_listen_q <= 1'b1;
      half_cnt_q    <= '0;
      shift_q       <= '0;
      bit_idx_q     <= '0;
      tx_act_q      <= 1'b0;
      rx_act_q      <= 1'b0;
      line_q        <= 1'b1;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        auto_listen_q <= cfg_wdata_i;
      end
      if (accept) begin
        half_cnt_q <= half_cnt_d;
        shift_q    <= shift_d;
        bit_idx_q  <= bit_idx_d;
        tx_act_q   <= tx_act_d;
        rx_act_q   <= rx_act_d;
        line_q     <= line_d;
        rd_ptr_q   <= rd_ptr_d;
        count_q    <= count_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // fifo memory and result payload; a write and a valid read never hit
  // the same entry, since the fifo is neither empty on a read nor full
  // on a write, and one item does only one of them
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      fifo_mem[wr_addr] <= shift_d;
    end
    if (accept) begin
      rd_data_q <= fifo_mem[rd_ptr_q];
      rsp_q     <= rsp_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.tx_level      = rsp_q.tx_level;
  assign rsp_o.rx_done       = rsp_q.rx_done;
  assign rsp_o.rx_data       = rsp_q.rx_data;
  assign rsp_o.read_data     = rsp_q.read_valid ? rd_data_q : '0;
  assign rsp_o.read_valid    = rsp_q.read_valid;
  assign rsp_o.send_accepted = rsp_q.send_accepted;
  assign rsp_o.tx_busy       = rsp_q.tx_busy;
  assign rsp_o.rx_busy       = rsp_q.rx_busy;
  assign rsp_o.fifo_count    = rsp_q.fifo_count;
  assign rsp_o.overflow      = rsp_q.overflow;

endmodule

@@ rtl/hdut_checker.sv @@
module hdut_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rx_done_i,
  input logic                         read_valid_i,
  input logic                         overflow_i,
  input logic [hdut_pkg::COUNT_W-1:0] fifo_count_i
);
  import hdut_pkg::*;

  logic [COUNT_W-1:0] last_count_q;
  logic               rsp_take;

  assign rsp_take = rsp_valid_i && rsp_ready_i;

  // fill count of the last result taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
    end else if (rsp_take) begin
      last_count_q <= fifo_count_i;
    end
  end

  // stalled result stays valid and keeps its fifo count
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(fifo_count_i))
    else $error("stalled result changed");

  // result shows in the cycle after its item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("result missing after accepted item");

  // stalled output back-pressures the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("item accepted while result stalled");

  // a successful read takes one byte out
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_take && read_valid_i |-> fifo_count_i == last_count_q - 1'b1)
    else $error("fifo count wrong after read");

  // a stored byte adds one
  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_take && rx_done_i && !overflow_i |-> fifo_count_i == last_count_q + 1'b1)
    else $error("fifo count wrong after receive");

endmodule

bind half_duplex_uart_transceiver hdut_checker u_hdut_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rx_done_i    (rsp_o.rx_done),
  .read_valid_i (rsp_o.read_valid),
  .overflow_i   (rsp_o.overflow),
  .fifo_count_i (rsp_o.fifo_count)
);
